FILE: sv/ptcm_pkg.sv
// ----------------------------------------------------------------------------
// ptcm_pkg
// shared types and constants of the planar texture coordinate mapper
// ----------------------------------------------------------------------------
package ptcm_pkg;

  // texture sizes, powers of two
  localparam int unsigned TEX_WIDTH  = 64;
  localparam int unsigned TEX_HEIGHT = 64;
  localparam int unsigned SHIFT_U    = $clog2(TEX_WIDTH);
  localparam int unsigned SHIFT_V    = $clog2(TEX_HEIGHT);

  // queue between front and back, power of two
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned IN_W  = 144;
  localparam int unsigned OUT_W = 64;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_U      = 3'd0,
    CFG_OFFSET_V      = 3'd1,
    CFG_RECIP_SCALE_U = 3'd2,
    CFG_RECIP_SCALE_V = 3'd3,
    CFG_COS_ANGLE     = 3'd4,
    CFG_SIN_ANGLE     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] offset_u;
    logic signed [31:0] offset_v;
    logic signed [31:0] recip_scale_u;
    logic signed [31:0] recip_scale_v;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
  } cfg_t;

  // projected plane point, v may reach 2^31
  typedef struct packed {
    logic signed [32:0] h;
    logic signed [32:0] v;
  } plane_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic s1_vld;
  } back_stat_t;

endpackage

FILE: sv/ptcm_front.sv
// ----------------------------------------------------------------------------
// ptcm_front
// input handshake and projection plane selection from the face normal
// ----------------------------------------------------------------------------
module ptcm_front import ptcm_pkg::*; (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z
  input  logic [IN_W-1:0] s_axis_tdata,
  input  q_stat_t         q_stat_i,
  output logic            push_o,
  output plane_t          item_o
);

  logic signed [31:0] px, py, pz;
  logic signed [16:0] nx, ny, nz;
  logic        [16:0] ax, ay, az;

  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];
  assign pz = s_axis_tdata[95:64];
  assign nx = {s_axis_tdata[111], s_axis_tdata[111:96]};
  assign ny = {s_axis_tdata[127], s_axis_tdata[127:112]};
  assign nz = {s_axis_tdata[143], s_axis_tdata[143:128]};

  assign ax = (nx < 0) ? 17'(-nx) : 17'(nx);
  assign ay = (ny < 0) ? 17'(-ny) : 17'(ny);
  assign az = (nz < 0) ? 17'(-nz) : 17'(nz);

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    if (ax >= ay && ax >= az) begin
      item_o.h = 33'(py);
      item_o.v = -33'(pz);
    end else if (ay >= az) begin
      item_o.h = 33'(px);
      item_o.v = -33'(pz);
    end else begin
      item_o.h = 33'(px);
      item_o.v = -33'(py);
    end
  end

endmodule

FILE: sv/ptcm_queue.sv
// ----------------------------------------------------------------------------
// ptcm_queue
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module ptcm_queue import ptcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  plane_t  item_i,
  input  logic    pop_i,
  output plane_t  head_o,
  output q_stat_t stat_o
);

  plane_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: sv/ptcm_back.sv
// ----------------------------------------------------------------------------
// ptcm_back
// rotation, scaling, offset and texture size shift in five stages
// ----------------------------------------------------------------------------
module ptcm_back import ptcm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  plane_t           head_i,
  input  q_stat_t          q_stat_i,
  output back_stat_t       stat_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // tex_u, tex_v
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic adv, pop;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;

  logic signed [48:0] hc_q, vs_q, vc_q, hs_q;
  logic signed [49:0] rot_u, rot_v;
  logic signed [31:0] r_u_q, r_v_q;
  logic signed [63:0] p_u_q, p_v_q;
  logic signed [64:0] rp_u, rp_v;
  logic signed [48:0] s_u_q, s_v_q;
  logic signed [49:0] t_u, t_v;
  logic signed [31:0] tex_u_q, tex_v_q, tex_u_d, tex_v_d;

  assign adv = !out_vld_q || m_axis_tready;
  assign pop = adv && !q_stat_i.empty;

  assign stat_o.pop    = pop;
  assign stat_o.s1_vld = s1_vld_q;

  assign rot_u = 50'(hc_q) + 50'(vs_q) + 50'sd8192;
  assign rot_v = 50'(vc_q) - 50'(hs_q) + 50'sd8192;
  assign rp_u  = 65'(p_u_q) + 65'sd32768;
  assign rp_v  = 65'(p_v_q) + 65'sd32768;
  assign t_u   = 50'(s_u_q) + 50'(cfg_i.offset_u);
  assign t_v   = 50'(s_v_q) + 50'(cfg_i.offset_v);
  assign tex_u_d = sat32(t_u >>> SHIFT_U);
  assign tex_v_d = sat32(t_v >>> SHIFT_V);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pop;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hc_q    <= 49'(head_i.h) * 49'(cfg_i.cos_angle);
      vs_q    <= 49'(head_i.v) * 49'(cfg_i.sin_angle);
      vc_q    <= 49'(head_i.v) * 49'(cfg_i.cos_angle);
      hs_q    <= 49'(head_i.h) * 49'(cfg_i.sin_angle);
      r_u_q   <= sat32(rot_u >>> 14);
      r_v_q   <= sat32(rot_v >>> 14);
      p_u_q   <= 64'(r_u_q) * 64'(cfg_i.recip_scale_u);
      p_v_q   <= 64'(r_v_q) * 64'(cfg_i.recip_scale_v);
      s_u_q   <= 49'(rp_u >>> 16);
      s_v_q   <= 49'(rp_v >>> 16);
      tex_u_q <= tex_u_d;
      tex_v_q <= tex_v_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {tex_v_q, tex_u_q};

endmodule

FILE: sv/planar_texture_coordinate_mapper_top.sv
// ----------------------------------------------------------------------------
// planar_texture_coordinate_mapper_top
// maps a point on a face to planar texture coordinates
//
//   channel  dir  beat content
//   s_axis   in   point_x, point_y, point_z, normal_x, normal_y, normal_z
//   m_axis   out  tex_u, tex_v
//   cfg      in   register index and write data, always ready
//
// one beat per cycle in and out while the output is not stalled; a result
// passes the queue and then the five-stage multiply pipeline of the back part
// reset restores the default registers and empties the queue
// an output stall freezes the back pipeline; a four-entry queue keeps
// taking input beats until it fills
// ----------------------------------------------------------------------------
module planar_texture_coordinate_mapper_top import ptcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tex_u, tex_v
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_t       cfg_q;
  q_stat_t    q_stat;
  back_stat_t back_stat;
  plane_t     front_item, q_head;
  logic       push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_u      <= '0;
      cfg_q.offset_v      <= '0;
      cfg_q.recip_scale_u <= 32'sd65536;
      cfg_q.recip_scale_v <= 32'sd65536;
      cfg_q.cos_angle     <= 16'sd16384;
      cfg_q.sin_angle     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_U:      cfg_q.offset_u      <= cfg_data_i;
        CFG_OFFSET_V:      cfg_q.offset_v      <= cfg_data_i;
        CFG_RECIP_SCALE_U: cfg_q.recip_scale_u <= cfg_data_i;
        CFG_RECIP_SCALE_V: cfg_q.recip_scale_v <= cfg_data_i;
        CFG_COS_ANGLE:     cfg_q.cos_angle     <= cfg_data_i[15:0];
        CFG_SIN_ANGLE:     cfg_q.sin_angle     <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  ptcm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .item_o        (front_item)
  );

  ptcm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (back_stat.pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  ptcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .stat_o        (back_stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_stall_no_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !back_stat.pop)
    else $error("back popped while output stalled");

  a_pop_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |=> back_stat.s1_vld)
    else $error("popped item did not enter first stage");

  a_accept_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

FILE: tb/planar_texture_coordinate_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// planar_texture_coordinate_mapper_top_tb
// self-checking bench for the planar texture coordinate mapper: streams
// points with face normals under random valid/ready idling, predicts each
// texture coordinate pair from its own copy of the mapping registers and
// checks every output beat in order; registers are reprogrammed between
// bursts once the block has drained
// ----------------------------------------------------------------------------
module planar_texture_coordinate_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptcm_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam cfg_t MAP_CFG_RESET = '{
    offset_u: 32'sd0, offset_v: 32'sd0,
    recip_scale_u: 32'sd65536, recip_scale_v: 32'sd65536,
    cos_angle: 16'sd16384, sin_angle: 16'sd0
  };

  typedef struct packed {
    logic signed [15:0] normal_z;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_x;
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } surface_point_t;

  typedef struct packed {
    logic signed [31:0] tex_v;
    logic signed [31:0] tex_u;
  } tex_coord_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  cfg_t       map_cfg;
  tex_coord_t tex_expect_q[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         rx_hold_toggle = 1'b0;

  planar_texture_coordinate_mapper_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint x);
    if (x > S32_MAX) return S32_MAX;
    if (x < S32_MIN) return S32_MIN;
    return x;
  endfunction

  // round the rotation, scale, offset and divide by the texture size for one axis
  function automatic logic [31:0] map_axis(input longint rot, input longint rscale,
                                           input longint off, input int unsigned shift);
    longint r;
    longint s;
    r = clamp32((rot + 8192) >>> 14);
    s = (r * rscale + 32768) >>> 16;
    return 32'(clamp32((s + off) >>> shift));
  endfunction

  function automatic tex_coord_t project_point(input surface_point_t p);
    longint ax, ay, az, h, v, rot_u, rot_v;
    tex_coord_t t;
    ax = p.normal_x;
    ay = p.normal_y;
    az = p.normal_z;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    if (ax >= ay && ax >= az) begin
      h = p.point_y;
      v = p.point_z;
    end else if (ay >= az) begin
      h = p.point_x;
      v = p.point_z;
    end else begin
      h = p.point_x;
      v = p.point_y;
    end
    v = -v;
    rot_u = h * map_cfg.cos_angle + v * map_cfg.sin_angle;
    rot_v = v * map_cfg.cos_angle - h * map_cfg.sin_angle;
    t.tex_u = map_axis(rot_u, map_cfg.recip_scale_u, map_cfg.offset_u, SHIFT_U);
    t.tex_v = map_axis(rot_v, map_cfg.recip_scale_v, map_cfg.offset_v, SHIFT_V);
    return t;
  endfunction

  // register writes, predictions and output checks
  always @(posedge clk_i) begin
    tex_coord_t want;
    tex_coord_t got;
    if (!rst_ni) begin
      map_cfg = MAP_CFG_RESET;
      tex_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OFFSET_U:      map_cfg.offset_u = cfg_data_i;
          CFG_OFFSET_V:      map_cfg.offset_v = cfg_data_i;
          CFG_RECIP_SCALE_U: map_cfg.recip_scale_u = cfg_data_i;
          CFG_RECIP_SCALE_V: map_cfg.recip_scale_v = cfg_data_i;
          CFG_COS_ANGLE:     map_cfg.cos_angle = cfg_data_i[15:0];
          CFG_SIN_ANGLE:     map_cfg.sin_angle = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tex_expect_q.push_back(project_point(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (tex_expect_q.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = tex_expect_q.pop_front();
          if (got.tex_u !== want.tex_u) begin
            $display("%0t tex_u mismatch: expected %h actual %h", $time, want.tex_u, got.tex_u);
            mismatch_count++;
          end
          if (got.tex_v !== want.tex_v) begin
            $display("%0t tex_v mismatch: expected %h actual %h", $time, want.tex_v, got.tex_v);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output ready with random idling and an occasional long hold-off
  initial begin : rx_ready_gen
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_toggle != hold_seen) begin
        hold_seen = rx_hold_toggle;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic surface_point_t mk_point(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [15:0] nx,
                                              input logic [15:0] ny, input logic [15:0] nz);
    surface_point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.normal_x = nx;
    p.normal_y = ny;
    p.normal_z = nz;
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
      3, 4: return $urandom;
      default: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  function automatic surface_point_t rand_point();
    surface_point_t p;
    logic [15:0] m;
    logic [15:0] sm;
    p.point_x = rand_coord();
    p.point_y = rand_coord();
    p.point_z = rand_coord();
    m = 16'($urandom);
    sm = $urandom_range(1) ? -m : m;
    case ($urandom_range(5))
      0: {p.normal_z, p.normal_y, p.normal_x} = {$urandom, 16'($urandom)};
      1: begin
        p.normal_x = 16'($urandom_range(32'h3ff)) - 16'h0200;
        p.normal_y = 16'($urandom_range(32'h3ff)) - 16'h0200;
        p.normal_z = 16'($urandom_range(32'h3ff)) - 16'h0200;
        case ($urandom_range(2))
          0: p.normal_x = $urandom_range(1) ? 16'h4000 : 16'hc000;
          1: p.normal_y = $urandom_range(1) ? 16'h4000 : 16'hc000;
          default: p.normal_z = $urandom_range(1) ? 16'h4000 : 16'hc000;
        endcase
      end
      2: begin
        // two components of equal magnitude
        {p.normal_z, p.normal_y, p.normal_x} = {$urandom, 16'($urandom)};
        case ($urandom_range(2))
          0: begin p.normal_x = m; p.normal_y = sm; end
          1: begin p.normal_y = m; p.normal_z = sm; end
          default: begin p.normal_x = sm; p.normal_z = m; end
        endcase
      end
      3: begin
        p.normal_x = 16'h0000;
        p.normal_y = 16'h0000;
        p.normal_z = 16'h0000;
      end
      default: begin
        p.normal_x = 16'($urandom_range(32768)) - 16'h4000;
        p.normal_y = 16'($urandom_range(32768)) - 16'h4000;
        p.normal_z = 16'($urandom_range(32768)) - 16'h4000;
      end
    endcase
    return p;
  endfunction

  function automatic logic [31:0] rand_word(input logic [31:0] typical);
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return typical;
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h4000 : 16'hc000;
      2: return 16'h0000;
      default: return 16'($urandom_range(32768)) - 16'h4000;
    endcase
  endfunction

  function automatic cfg_t rand_mapping();
    cfg_t c;
    c.offset_u = rand_word($urandom_range(32'h001f_ffff) - 32'h0010_0000);
    c.offset_v = rand_word($urandom_range(32'h001f_ffff) - 32'h0010_0000);
    c.recip_scale_u = rand_word($urandom_range(32'h0003_ffff) - 32'h0001_0000);
    c.recip_scale_v = rand_word($urandom_range(32'h0003_ffff) - 32'h0001_0000);
    c.cos_angle = rand_trig();
    c.sin_angle = rand_trig();
    return c;
  endfunction

  task automatic send_point(input surface_point_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    do @(negedge clk_i); while (tex_expect_q.size() != 0);
    @(posedge clk_i);
  endtask

  // stop the stream and let the block drain completely
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_mapping(input cfg_t c);
    quiesce();
    write_reg(CFG_OFFSET_U, c.offset_u);
    write_reg(CFG_OFFSET_V, c.offset_v);
    write_reg(CFG_RECIP_SCALE_U, c.recip_scale_u);
    write_reg(CFG_RECIP_SCALE_V, c.recip_scale_v);
    write_reg(CFG_COS_ANGLE, {16'($urandom), c.cos_angle});
    write_reg(CFG_SIN_ANGLE, {16'($urandom), c.sin_angle});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_mapping();
    tx_idle_pct = 14;
    rx_idle_pct = 50;
    send_point(mk_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0000, 16'h0000,
                        16'h0000));
    send_point(mk_point(32'h0001_8000, 32'hfffe_4000, 32'h0040_0000, 16'h4000, 16'h0000,
                        16'h0000));
    send_point(mk_point(32'h0001_8000, 32'hfffe_4000, 32'h0040_0000, 16'h0000, 16'h4000,
                        16'h0000));
    send_point(mk_point(32'h0001_8000, 32'hfffe_4000, 32'h0040_0000, 16'h0000, 16'h0000,
                        16'h4000));
    send_point(mk_point(32'hffc0_0000, 32'h0123_4567, 32'h89ab_cdef, 16'h0000, 16'h0000,
                        16'hc000));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'h1f40, 16'he0c0,
                        16'h0064));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'h000a, 16'hdcd8,
                        16'h2328));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'hec78, 16'h0000,
                        16'h1388));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'h8000, 16'h7fff,
                        16'h0000));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'h7fff, 16'h8000,
                        16'h0000));
    send_point(mk_point(32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 16'h0000, 16'h7fff,
                        16'h8000));
    send_point(mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 16'h0000,
                        16'h4000));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h4000, 16'h0000,
                        16'h0000));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'hc000,
                        16'h0000));
  endtask

  task automatic test_extreme_registers();
    cfg_t c;
    c = '{offset_u: 32'h7fff_ffff, offset_v: 32'h7fff_ffff,
          recip_scale_u: 32'h7fff_ffff, recip_scale_v: 32'h7fff_ffff,
          cos_angle: 16'h8000, sin_angle: 16'h7fff};
    program_mapping(c);
    send_point(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h4000, 16'h0000,
                        16'h0000));
    send_point(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h0000, 16'h4000,
                        16'h0000));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 16'h0000, 16'h0000,
                        16'h8000));
    send_point(mk_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0000, 16'hffff, 16'h0001,
                        16'h0000));
    c = '{offset_u: 32'h8000_0000, offset_v: 32'h8000_0000,
          recip_scale_u: 32'h8000_0000, recip_scale_v: 32'h8000_0000,
          cos_angle: 16'hc000, sin_angle: 16'h4000};
    program_mapping(c);
    send_point(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h4000, 16'h0000,
                        16'h0000));
    send_point(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h0000, 16'h4000,
                        16'h0000));
    send_point(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000,
                        16'h7fff));
    send_point(mk_point(32'h0000_8000, 32'hffff_8000, 32'h0000_2000, 16'h0000, 16'h0000,
                        16'h0000));
  endtask

  task automatic test_unused_register_index();
    quiesce();
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    cfg_valid_i <= 1'b0;
    send_point(rand_point());
    send_point(rand_point());
  endtask

  task automatic test_output_backpressure();
    program_mapping(MAP_CFG_RESET);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_toggle = ~rx_hold_toggle;
    repeat (40) send_point(rand_point());
    quiesce();
    repeat (20) send_point(rand_point());
  endtask

  task automatic test_random_streams();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 14; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        program_mapping(rand_mapping());
        repeat (100) send_point(rand_point());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_mapping();
    test_extreme_registers();
    test_unused_register_index();
    test_output_backpressure();
    test_random_streams();

    quiesce();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ptcm_pkg.sv
sv/ptcm_front.sv
sv/ptcm_queue.sv
sv/ptcm_back.sv
sv/planar_texture_coordinate_mapper_top.sv
tb/planar_texture_coordinate_mapper_top_tb.sv
